/* hdl/swfd_pkg.sv */
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types and constants of the sync word frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swfd_pkg;

	localparam logic [31:0] SYNC_MARK   = 32'hD391A6C5;
	localparam int          SYNC_LEN    = 32;
	localparam int          FILL_W      = 6;
	localparam int          LEN_BYTES   = 4;
	localparam int          CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM     = 2'd2;

	localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

	localparam logic [2:0] ST_NONE      = 3'd0;
	localparam logic [2:0] ST_LOCKED    = 3'd1;
	localparam logic [2:0] ST_RECEIVING = 3'd2;
	localparam logic [2:0] ST_COMPLETE  = 3'd3;
	localparam logic [2:0] ST_ERROR     = 3'd4;

	typedef struct packed {
		logic       restart;
		logic [3:0] bit_branch;
		logic       bit_value;
		logic       bit_certain;
		logic [7:0] bit_confidence;
	} item_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic        byte_certain;
		logic [7:0]  byte_confidence;
		logic [2:0]  frame_status;
		logic        is_locked;
	} result_t;

	typedef struct packed {
		logic shift_en;
		logic clear;
	} corr_ctl_t;

	typedef struct packed {
		logic in_range;
		logic match;
	} corr_stat_t;

	typedef struct packed {
		logic [31:0] max_payload_len;
		logic [3:0]  sync_error_limit;
		logic        stream_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* hdl/swfd_corr.sv */
// ----------------------------------------------------------------------------
// swfd_corr
// Per-branch sync word shift registers with fill counters and a tolerant
// match against the sync word for the branch of the current bit.
// ----------------------------------------------------------------------------
`default_nettype none

module swfd_corr
	import swfd_pkg::*;
#(
	parameter int NUM_BRANCHES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [3:0] bit_branch,
	input  wire logic       bit_value,
	input  wire logic [3:0] sync_error_limit,
	input  wire corr_ctl_t  ctl,
	output corr_stat_t      stat
);

	logic [31:0]       shift_q [NUM_BRANCHES];
	logic [FILL_W-1:0] fill_q  [NUM_BRANCHES];
	logic [31:0]       shift_nxt [NUM_BRANCHES];
	logic [FILL_W-1:0] fill_nxt  [NUM_BRANCHES];
	logic [NUM_BRANCHES-1:0] hit;
	logic [31:0]       sel_shift;
	logic [FILL_W-1:0] sel_fill;
	logic [FILL_W-1:0] err_cnt;

	always_comb begin
		sel_shift = '0;
		sel_fill  = '0;
		for (int b = 0; b < NUM_BRANCHES; b++) begin
			hit[b]       = (bit_branch == 4'(b));
			shift_nxt[b] = {shift_q[b][30:0], bit_value};
			fill_nxt[b]  = (fill_q[b] < FILL_W'(SYNC_LEN)) ? fill_q[b] + 1'b1 : fill_q[b];
			if (hit[b]) begin
				sel_shift = shift_nxt[b];
				sel_fill  = fill_nxt[b];
			end
		end
	end

	assign err_cnt       = FILL_W'($countones(sel_shift ^ SYNC_MARK));
	assign stat.in_range = ({1'b0, bit_branch} < 5'(NUM_BRANCHES));
	assign stat.match    = (sel_fill == FILL_W'(SYNC_LEN)) &&
	                       (err_cnt <= {{(FILL_W-4){1'b0}}, sync_error_limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BRANCHES; b++) begin
				shift_q[b] <= '0;
				fill_q[b]  <= '0;
			end
		end else if (ctl.clear) begin
			for (int b = 0; b < NUM_BRANCHES; b++) begin
				shift_q[b] <= '0;
				fill_q[b]  <= '0;
			end
		end else if (ctl.shift_en) begin
			for (int b = 0; b < NUM_BRANCHES; b++) begin
				if (hit[b]) begin
					shift_q[b] <= shift_nxt[b];
					fill_q[b]  <= fill_nxt[b];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/swfd_parse.sv */
// ----------------------------------------------------------------------------
// swfd_parse
// Lock tracking, byte packing and length / payload parsing for one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module swfd_parse
	import swfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire item_t      item,
	input  wire cfg_t       cfg,
	input  wire corr_stat_t stat,
	output corr_ctl_t       ctl,
	output result_t         res
);

	localparam logic [1:0] PH_SEARCH  = 2'd0;
	localparam logic [1:0] PH_LENGTH  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic        lock_q, lock_nxt;
	logic [3:0]  branch_q, branch_nxt;
	logic [1:0]  phase_q, phase_nxt;
	logic [7:0]  accum_q, accum_nxt;
	logic [2:0]  bitcnt_q, bitcnt_nxt;
	logic        acert_q, acert_nxt;
	logic [7:0]  aconf_q, aconf_nxt;
	logic [31:0] flen_q, flen_nxt;
	logic [1:0]  lcnt_q, lcnt_nxt;
	logic [31:0] pcnt_q, pcnt_nxt;

	logic [7:0]  b_val;
	logic        b_cert;
	logic [7:0]  b_conf;
	logic [31:0] flen_new;
	logic [31:0] pcnt_new;
	logic        do_restart;
	logic        searching;

	always_comb begin
		lock_nxt   = lock_q;
		branch_nxt = branch_q;
		phase_nxt  = phase_q;
		accum_nxt  = accum_q;
		bitcnt_nxt = bitcnt_q;
		acert_nxt  = acert_q;
		aconf_nxt  = aconf_q;
		flen_nxt   = flen_q;
		lcnt_nxt   = lcnt_q;
		pcnt_nxt   = pcnt_q;
		do_restart = 1'b0;
		res        = '0;

		b_val    = {accum_q[6:0], item.bit_value};
		b_cert   = acert_q & item.bit_certain;
		b_conf   = (item.bit_confidence < aconf_q) ? item.bit_confidence : aconf_q;
		flen_new = {flen_q[23:0], b_val};
		pcnt_new = pcnt_q + 32'd1;
		searching = !item.restart && stat.in_range && !lock_q;

		if (item.restart) begin
			do_restart = 1'b1;
		end else if (stat.in_range) begin
			if (!lock_q) begin
				if (stat.match) begin
					lock_nxt         = 1'b1;
					branch_nxt       = item.bit_branch;
					accum_nxt        = '0;
					bitcnt_nxt       = '0;
					acert_nxt        = 1'b1;
					aconf_nxt        = 8'hFF;
					phase_nxt        = cfg.stream_mode ? PH_PAYLOAD : PH_LENGTH;
					flen_nxt         = '0;
					lcnt_nxt         = '0;
					res.frame_status = ST_LOCKED;
				end
			end else if (item.bit_branch == branch_q && phase_q != PH_SEARCH) begin
				accum_nxt  = b_val;
				acert_nxt  = b_cert;
				aconf_nxt  = b_conf;
				bitcnt_nxt = bitcnt_q + 3'd1;
				if (bitcnt_q == 3'd7) begin
					accum_nxt = '0;
					acert_nxt = 1'b1;
					aconf_nxt = 8'hFF;
					if (phase_q == PH_LENGTH) begin
						flen_nxt = flen_new;
						lcnt_nxt = lcnt_q + 2'd1;
						if (lcnt_q == 2'(LEN_BYTES - 1)) begin
							if (flen_new > cfg.max_payload_len) begin
								res.frame_status = ST_ERROR;
								do_restart       = 1'b1;
							end else if (flen_new == '0) begin
								res.frame_status = ST_COMPLETE;
								do_restart       = 1'b1;
							end else begin
								pcnt_nxt  = '0;
								phase_nxt = PH_PAYLOAD;
							end
						end
					end else begin
						res.byte_valid      = 1'b1;
						res.payload_byte    = b_val;
						res.byte_certain    = b_cert;
						res.byte_confidence = b_conf;
						pcnt_nxt            = pcnt_new;
						if (!cfg.stream_mode && pcnt_new == flen_q) begin
							res.frame_status = ST_COMPLETE;
							do_restart       = 1'b1;
						end else begin
							res.frame_status = ST_RECEIVING;
						end
					end
				end
			end
		end

		if (do_restart) begin
			lock_nxt   = 1'b0;
			branch_nxt = '0;
			phase_nxt  = PH_SEARCH;
			accum_nxt  = '0;
			bitcnt_nxt = '0;
			acert_nxt  = 1'b1;
			aconf_nxt  = 8'hFF;
			flen_nxt   = '0;
			lcnt_nxt   = '0;
			pcnt_nxt   = '0;
		end
		res.is_locked = lock_nxt;

		ctl.clear    = step && do_restart;
		ctl.shift_en = step && searching;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q   <= 1'b0;
			branch_q <= '0;
			phase_q  <= PH_SEARCH;
			accum_q  <= '0;
			bitcnt_q <= '0;
			acert_q  <= 1'b1;
			aconf_q  <= 8'hFF;
			flen_q   <= '0;
			lcnt_q   <= '0;
			pcnt_q   <= '0;
		end else if (step) begin
			lock_q   <= lock_nxt;
			branch_q <= branch_nxt;
			phase_q  <= phase_nxt;
			accum_q  <= accum_nxt;
			bitcnt_q <= bitcnt_nxt;
			acert_q  <= acert_nxt;
			aconf_q  <= aconf_nxt;
			flen_q   <= flen_nxt;
			lcnt_q   <= lcnt_nxt;
			pcnt_q   <= pcnt_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/sync_word_frame_deframer.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_deframer
// Soft bit deframer: per-branch sync word search, lock, byte packing and
// length-prefixed or continuous payload extraction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   restart, bit_branch, bit_*
//  result    out        result_valid / result_stall  byte_*, payload_byte, ...
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One beat per cycle sustained while result_stall is low; each beat passes the
//  input register, then the parse logic into the result register.
//  The state of one bit is complete in the cycle it leaves the input register.
//  arst_n clears all parser state and loads register defaults.
//  A stalled result holds the input register, which then stalls the item side.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_frame_deframer
	import swfd_pkg::*;
#(
	parameter int NUM_BRANCHES = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic                 restart,
	input  wire logic [3:0]           bit_branch,
	input  wire logic                 bit_value,
	input  wire logic                 bit_certain,
	input  wire logic [7:0]           bit_confidence,

	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      byte_valid,
	output logic [7:0]                payload_byte,
	output logic                      byte_certain,
	output logic [7:0]                byte_confidence,
	output logic [2:0]                frame_status,
	output logic                      is_locked,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	result_t    res;
	corr_ctl_t  ctl;
	corr_stat_t stat;
	logic       adv;
	logic       take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_len  <= MAX_LEN_RESET;
			cfg_q.sync_error_limit <= '0;
			cfg_q.stream_mode      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_LEN:   cfg_q.max_payload_len  <= cfg_data;
				CFG_ERR_LIMIT: cfg_q.sync_error_limit <= cfg_data[3:0];
				CFG_STREAM:    cfg_q.stream_mode      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv        = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.restart        <= restart;
			item_s1.bit_branch     <= bit_branch;
			item_s1.bit_value      <= bit_value;
			item_s1.bit_certain    <= bit_certain;
			item_s1.bit_confidence <= bit_confidence;
		end
	end

	swfd_corr #(
		.NUM_BRANCHES(NUM_BRANCHES)
	) u_corr (
		.clk              (clk),
		.arst_n           (arst_n),
		.bit_branch       (item_s1.bit_branch),
		.bit_value        (item_s1.bit_value),
		.sync_error_limit (cfg_q.sync_error_limit),
		.ctl              (ctl),
		.stat             (stat)
	);

	swfd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.stat   (stat),
		.ctl    (ctl),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result_valid    = valid_s2;
	assign byte_valid      = res_s2.byte_valid;
	assign payload_byte    = res_s2.payload_byte;
	assign byte_certain    = res_s2.byte_certain;
	assign byte_confidence = res_s2.byte_confidence;
	assign frame_status    = res_s2.frame_status;
	assign is_locked       = res_s2.is_locked;

endmodule

`default_nettype wire
